// File: rtl/force_trigger_ema_hysteresis_defines.svh
// assertion helpers for the force trigger block
`ifndef FORCE_TRIGGER_EMA_HYSTERESIS_DEFINES_SVH
`define FORCE_TRIGGER_EMA_HYSTERESIS_DEFINES_SVH

`ifndef SYNTH

// checked only outside reset
`define FTEMA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ftema check failed");

// checked during reset as well
`define FTEMA_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("ftema reset check failed");

`else

`define FTEMA_ASSERT(label, prop)
`define FTEMA_ASSERT_RST(label, prop)

`endif

`endif

// File: rtl/ftema_pkg.sv
`default_nettype none

package ftema_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int LEVEL_W      = 15;
    localparam int ALPHA_W      = 16;
    localparam int COUNT_W      = 16;
    localparam int CMD_W        = 16;
    localparam int PHASE_W      = 2;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // magnitude width covers both the sample and the saturation limit
    localparam int MAG_W  = (SAMPLE_WIDTH + 1 > LEVEL_W + 1) ? SAMPLE_WIDTH + 1 : LEVEL_W + 1;
    localparam int PROD_W = ALPHA_W + LEVEL_W + 2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 16'd6554;
    localparam logic [LEVEL_W-1:0] THRESH_HI_RESET = 15'd26;
    localparam logic [LEVEL_W-1:0] THRESH_LO_RESET = 15'd20;
    localparam logic [COUNT_W-1:0] DELAY_RESET     = 16'd100;
    localparam logic [CMD_W-1:0]   COMMAND_RESET   = 16'hFD00;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_ARMED   = 3'b010,
        MODE_LOWERED = 3'b100
    } t_mode;

    typedef logic [PHASE_W-1:0] t_phase;

    localparam t_phase PHASE_IDLE    = 2'd0;
    localparam t_phase PHASE_ARMED   = 2'd1;
    localparam t_phase PHASE_LOWERED = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALPHA     = 3'd0,
        CFG_THRESH_HI = 3'd1,
        CFG_THRESH_LO = 3'd2,
        CFG_DELAY     = 3'd3,
        CFG_COMMAND   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [ALPHA_W-1:0]             alpha;
        logic [LEVEL_W-1:0]             level;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } t_filter_in;

    function automatic t_phase mode_to_phase(input t_mode m);
        t_phase p;
        case (m)
            MODE_IDLE:    p = PHASE_IDLE;
            MODE_ARMED:   p = PHASE_ARMED;
            MODE_LOWERED: p = PHASE_LOWERED;
            default:      p = PHASE_LOWERED;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ftema_in_if.sv
`default_nettype none

interface ftema_in_if
    import ftema_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic signed [SAMPLE_WIDTH-1:0] force_sample;

    modport source (output valid, output operation, output force_sample, input ready);
    modport sink   (input valid, input operation, input force_sample, output ready);
endinterface

`default_nettype wire

// File: rtl/ftema_out_if.sv
`default_nettype none

interface ftema_out_if
    import ftema_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [LEVEL_W-1:0]      filtered_level;
    logic [PHASE_W-1:0]      phase;
    logic                    command_valid;
    logic signed [CMD_W-1:0] command_out;

    modport source (
        output valid, output filtered_level, output phase,
        output command_valid, output command_out, input ready
    );
    modport sink (
        input valid, input filtered_level, input phase,
        input command_valid, input command_out, output ready
    );
endinterface

`default_nettype wire

// File: rtl/force_trigger_ema_hysteresis.sv
// Force-triggered delayed command with a moving-average filter and hysteresis.
// Input channel i_in carries transactions of two kinds: operation 0 is a signed
// force sample, operation 1 is a time tick. Output channel o_out returns exactly
// one result transaction per input: the filtered level and phase after that item,
// plus the drive command when the armed delay expires on a tick.
// Configuration (alpha, thresholds, delay, command level) is written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must write it only while no
// transaction is in flight, as the block does not enforce this. An accepted
// transaction lands in the input register; its result is loaded into the output
// register once that is empty or o_out is ready. Throughput is one transaction
// per cycle while o_out does not stall; the filter multiply-add and the
// threshold compares sit in one stage between the two registers.
// When o_out stalls, the output register holds its result and the input register
// keeps the next transaction; i_in.ready drops only when both are occupied.
// Synchronous reset restores the register defaults, clears the filter, the tick
// count and both valid flags, and puts the block in the idle phase.
`default_nettype none

`include "force_trigger_ema_hysteresis_defines.svh"

module force_trigger_ema_hysteresis
    import ftema_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    ftema_in_if.sink                    i_in,
    ftema_out_if.source                 o_out,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [ALPHA_W-1:0] r_alpha;
    logic [LEVEL_W-1:0] r_thresh_hi;
    logic [LEVEL_W-1:0] r_thresh_lo;
    logic [COUNT_W-1:0] r_delay;
    logic [CMD_W-1:0]   r_command;

    logic [LEVEL_W-1:0] r_filter;
    t_mode              r_mode;
    logic [COUNT_W-1:0] r_tick_count;

    logic                           r_in_valid;
    logic                           r_op;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;

    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;
    t_phase             r_out_phase;
    logic               r_out_cmd_valid;
    logic [CMD_W-1:0]   r_out_cmd;

    logic               w_advance;
    logic               w_fire;
    logic               w_accept;
    t_filter_in         w_filter_op;
    logic [LEVEL_W-1:0] w_filter_next;
    logic [COUNT_W-1:0] w_tick_inc;

    logic [LEVEL_W-1:0] n_filter;
    t_mode              n_mode;
    logic [COUNT_W-1:0] n_tick_count;
    logic               n_cmd_valid;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_filter_op = '{alpha: r_alpha, level: r_filter, sample: r_sample};

    ftema_filter u_filter (
        .i_op    (w_filter_op),
        .o_level (w_filter_next)
    );

    assign w_tick_inc = r_tick_count + COUNT_W'(1);

    always_comb begin
        n_filter     = r_filter;
        n_mode       = r_mode;
        n_tick_count = r_tick_count;
        n_cmd_valid  = 1'b0;
        if (r_op == OP_SAMPLE) begin
            n_filter = w_filter_next;
            if (r_mode == MODE_IDLE && w_filter_next > r_thresh_hi) begin
                n_mode       = MODE_ARMED;
                n_tick_count = '0;
            end else if (r_mode != MODE_IDLE && w_filter_next < r_thresh_lo) begin
                n_mode       = MODE_IDLE;
                n_tick_count = '0;
            end
        end else if (r_mode == MODE_ARMED) begin
            // a zero delay fires on the first tick; a wrapped count fires too
            if (w_tick_inc >= r_delay || w_tick_inc == '0) begin
                n_cmd_valid  = 1'b1;
                n_mode       = MODE_LOWERED;
                n_tick_count = '0;
            end else begin
                n_tick_count = w_tick_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RESET;
            r_thresh_hi <= THRESH_HI_RESET;
            r_thresh_lo <= THRESH_LO_RESET;
            r_delay     <= DELAY_RESET;
            r_command   <= COMMAND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA:     r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                CFG_THRESH_HI: r_thresh_hi <= i_cfg_data[LEVEL_W-1:0];
                CFG_THRESH_LO: r_thresh_lo <= i_cfg_data[LEVEL_W-1:0];
                CFG_DELAY:     r_delay     <= i_cfg_data[COUNT_W-1:0];
                CFG_COMMAND:   r_command   <= i_cfg_data[CMD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter     <= '0;
            r_mode       <= MODE_IDLE;
            r_tick_count <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_fire) begin
                r_filter     <= n_filter;
                r_mode       <= n_mode;
                r_tick_count <= n_tick_count;
            end
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_in.operation;
            r_sample <= i_in.force_sample;
        end
        if (w_fire) begin
            r_out_level     <= n_filter;
            r_out_phase     <= mode_to_phase(n_mode);
            r_out_cmd_valid <= n_cmd_valid;
            r_out_cmd       <= n_cmd_valid ? r_command : '0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.filtered_level = r_out_level;
    assign o_out.phase          = r_out_phase;
    assign o_out.command_valid  = r_out_cmd_valid;
    assign o_out.command_out    = r_out_cmd;

    `FTEMA_ASSERT(a_cmd_only_when_lowered, (r_out_valid && r_out_cmd_valid) |-> (r_out_phase == PHASE_LOWERED))
    `FTEMA_ASSERT(a_count_only_when_armed, (r_mode != MODE_ARMED) |-> (r_tick_count == '0))
    `FTEMA_ASSERT(a_cmd_zero_when_idle, (r_out_valid && !r_out_cmd_valid) |-> (r_out_cmd == '0))
    `FTEMA_ASSERT_RST(a_reset_clears_output, (!i_rst_n) |=> (!r_out_valid && !r_in_valid))

endmodule

`default_nettype wire

// File: rtl/ftema_filter.sv
`default_nettype none

module ftema_filter
    import ftema_pkg::*;
(
    input  t_filter_in         i_op,
    output logic [LEVEL_W-1:0] o_level
);

    logic signed [MAG_W-1:0]      w_sample_ext;
    logic [MAG_W-1:0]             w_abs;
    logic [LEVEL_W-1:0]           w_mag;
    logic signed [LEVEL_W:0]      w_diff;
    logic signed [ALPHA_W:0]      w_alpha_s;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [PROD_W-ALPHA_W-1:0] w_step;
    logic signed [LEVEL_W+2:0]    w_sum;

    always_comb begin
        w_sample_ext = MAG_W'(i_op.sample);
        w_abs = w_sample_ext[MAG_W-1] ? MAG_W'(-w_sample_ext) : MAG_W'(w_sample_ext);
        w_mag = (w_abs > MAG_W'(LEVEL_MAX)) ? LEVEL_MAX : w_abs[LEVEL_W-1:0];

        w_diff    = signed'({1'b0, w_mag}) - signed'({1'b0, i_op.level});
        w_alpha_s = signed'({1'b0, i_op.alpha});
        w_prod    = PROD_W'(w_alpha_s) * PROD_W'(w_diff);
        // arithmetic shift floors the scaled step
        w_step    = w_prod[PROD_W-1:ALPHA_W];
        w_sum     = signed'({3'b000, i_op.level}) + (LEVEL_W+3)'(w_step);

        if (w_sum[LEVEL_W+2]) begin
            o_level = '0;
        end else if (w_sum[LEVEL_W+1:LEVEL_W] != 2'b00) begin
            o_level = LEVEL_MAX;
        end else begin
            o_level = w_sum[LEVEL_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: tb/force_trigger_ema_hysteresis_test.sv
`timescale 1ns / 1ps

module force_trigger_ema_hysteresis_test;
    import ftema_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int REPORT_LIMIT  = 10;
    localparam int LONG_DELAY    = 200;

    typedef struct packed {
        logic [LEVEL_W-1:0]      level;
        t_phase                  phase;
        logic                    command_valid;
        logic signed [CMD_W-1:0] command_out;
    } t_trigger_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ftema_in_if  in_ch ();
    ftema_out_if out_ch ();

    force_trigger_ema_hysteresis uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // register copies and filter state of the trigger
    logic [ALPHA_W-1:0]      m_alpha;
    logic [LEVEL_W-1:0]      m_thr_hi;
    logic [LEVEL_W-1:0]      m_thr_lo;
    logic [COUNT_W-1:0]      m_delay;
    logic signed [CMD_W-1:0] m_command;
    logic [LEVEL_W-1:0]      m_level;
    t_phase                  m_phase;
    logic [COUNT_W-1:0]      m_ticks;

    t_trigger_result trigger_outputs[$];
    int              fault_count;
    int              cycle_count;
    bit              sender_idle;
    bit              receiver_idle;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("force_trigger_ema_hysteresis regression: fail");
            $finish;
        end
    end

    function automatic void filter_and_trigger(input logic op,
                                               input logic signed [SAMPLE_WIDTH-1:0] smp);
        t_trigger_result r;
        longint          mag;
        longint          prod;
        longint          next_level;
        r.command_valid = 1'b0;
        r.command_out   = '0;
        if (op == OP_SAMPLE) begin
            mag = smp;
            if (mag < 0) mag = -mag;
            if (mag > longint'(LEVEL_MAX)) mag = longint'(LEVEL_MAX);
            prod = longint'(m_alpha) * (mag - longint'(m_level));
            // arithmetic shift floors toward minus infinity
            next_level = longint'(m_level) + (prod >>> 16);
            if (next_level < 0) begin
                next_level = 0;
            end else if (next_level > longint'(LEVEL_MAX)) begin
                next_level = longint'(LEVEL_MAX);
            end
            m_level = next_level[LEVEL_W-1:0];
            if (m_phase == PHASE_IDLE && m_level > m_thr_hi) begin
                m_phase = PHASE_ARMED;
                m_ticks = '0;
            end else if (m_phase != PHASE_IDLE && m_level < m_thr_lo) begin
                m_phase = PHASE_IDLE;
                m_ticks = '0;
            end
        end else if (m_phase == PHASE_ARMED) begin
            m_ticks = m_ticks + 1'b1;
            // a zero delay behaves as one tick
            if (m_ticks >= m_delay || m_ticks == '0) begin
                r.command_valid = 1'b1;
                r.command_out   = m_command;
                m_phase         = PHASE_LOWERED;
                m_ticks         = '0;
            end
        end
        r.level = m_level;
        r.phase = m_phase;
        trigger_outputs.push_back(r);
    endfunction

    task automatic send_item(input logic op, input logic signed [SAMPLE_WIDTH-1:0] smp);
        int gap;
        gap = sender_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= op;
        in_ch.force_sample <= smp;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        filter_and_trigger(op, smp);
    endtask

    // tick payload is don't-care, so give it noise
    task automatic send_tick();
        send_item(OP_TICK, SAMPLE_WIDTH'($urandom));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (trigger_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ALPHA:     m_alpha   = data;
            CFG_THRESH_HI: m_thr_hi  = data[LEVEL_W-1:0];
            CFG_THRESH_LO: m_thr_lo  = data[LEVEL_W-1:0];
            CFG_DELAY:     m_delay   = data;
            CFG_COMMAND:   m_command = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [ALPHA_W-1:0] alpha, input logic [LEVEL_W-1:0] hi,
                             input logic [LEVEL_W-1:0] lo, input logic [COUNT_W-1:0] delay,
                             input logic [CMD_W-1:0] command);
        write_register(CFG_ALPHA, alpha);
        write_register(CFG_THRESH_HI, CFG_DATA_W'(hi));
        write_register(CFG_THRESH_LO, CFG_DATA_W'(lo));
        write_register(CFG_DELAY, delay);
        write_register(CFG_COMMAND, command);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] force_with_magnitude(input int lo_mag,
                                                                            input int hi_mag);
        int v;
        v = $urandom_range(lo_mag, hi_mag);
        if (v == 32767 && $urandom_range(0, 3) == 0) begin
            v = -32768;
        end else if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return SAMPLE_WIDTH'(v);
    endfunction

    initial begin : result_sink
        t_trigger_result want;
        int              stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = receiver_idle ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1) @(posedge i_clk);
            if (trigger_outputs.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing pending: level %0d phase %0d cmd %0b/%0d",
                             $time, out_ch.filtered_level, out_ch.phase,
                             out_ch.command_valid, out_ch.command_out);
            end else begin
                want = trigger_outputs.pop_front();
                if (out_ch.filtered_level !== want.level || out_ch.phase !== want.phase ||
                    out_ch.command_valid !== want.command_valid ||
                    out_ch.command_out !== want.command_out) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display({"%0t: mismatch level exp %0d got %0d, phase exp %0d got %0d, ",
                                  "cmd_valid exp %0b got %0b, cmd exp %0d got %0d"},
                                 $time, want.level, out_ch.filtered_level, want.phase,
                                 out_ch.phase, want.command_valid, out_ch.command_valid,
                                 want.command_out, out_ch.command_out);
                end
            end
        end
    end

    task automatic test_reset_defaults();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        send_item(OP_SAMPLE, 16'sd0);
        send_tick();
        // largest negative sample saturates and arms with the default alpha
        send_item(OP_SAMPLE, -16'sd32768);
        send_tick();
        send_item(OP_SAMPLE, 16'sd32767);
        send_item(OP_SAMPLE, -16'sd32767);
        drain_results();
    endtask

    task automatic test_short_delays();
        configure(16'hFFFF, 15'd100, 15'd80, 16'd0, 16'h7FFF);
        send_tick();
        send_tick();
        send_item(OP_SAMPLE, 16'sd0);
        send_tick();
        send_item(OP_SAMPLE, 16'sd200);
        drain_results();
        write_register(CFG_DELAY, 16'd1);
        cfg_we <= 1'b0;
        send_tick();
        send_tick();
        drain_results();
    endtask

    task automatic test_threshold_extremes();
        // low threshold above high one: arm and release alternate
        configure(16'hFFFF, 15'd10, 15'd20000, 16'd2, 16'h8000);
        send_item(OP_SAMPLE, 16'sd1000);
        send_item(OP_SAMPLE, -16'sd1000);
        send_item(OP_SAMPLE, 16'sd1000);
        drain_results();
        configure(16'h8000, 15'd0, 15'd0, 16'd2, 16'h0000);
        send_item(OP_SAMPLE, 16'sd0);
        send_tick();
        send_tick();
        send_item(OP_SAMPLE, 16'sd0);
        drain_results();
        configure(16'hFFFF, 15'h7FFF, 15'h7FFF, 16'd1, 16'h0001);
        send_item(OP_SAMPLE, 16'sd32767);
        send_item(OP_SAMPLE, -16'sd32768);
        send_tick();
        drain_results();
    endtask

    task automatic test_unused_index();
        for (int i = CFG_COMMAND + 1; i < 2 ** CFG_INDEX_W; i++)
            write_register(CFG_INDEX_W'(i), '0);
        for (int i = CFG_COMMAND + 1; i < 2 ** CFG_INDEX_W; i++)
            write_register(CFG_INDEX_W'(i), '1);
        cfg_we <= 1'b0;
        send_item(OP_SAMPLE, 16'sd12345);
        send_tick();
        drain_results();
    endtask

    task automatic test_longest_delay();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        configure(16'hFFFF, 15'd100, 15'd80, COUNT_W'(LONG_DELAY), 16'hFD00);
        send_item(OP_SAMPLE, 16'sd0);
        send_item(OP_SAMPLE, 16'sd32767);
        // a long tick run back to back before the command fires
        repeat (LONG_DELAY - 1) send_tick();
        send_tick();
        drain_results();
    endtask

    task automatic test_random_traffic();
        int                 sent;
        int                 phase_end;
        int                 n;
        int                 kind;
        logic [ALPHA_W-1:0] a;
        logic [LEVEL_W-1:0] hi;
        logic [LEVEL_W-1:0] lo;
        logic [COUNT_W-1:0] d;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            case ($urandom_range(0, 7))
                0:       a = '0;
                1:       a = '1;
                default: a = ALPHA_W'($urandom_range(2048, 65535));
            endcase
            hi = ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom_range(0, 32767))
                                             : LEVEL_W'($urandom_range(0, 4000));
            lo = ($urandom_range(0, 4) == 0) ? LEVEL_W'($urandom_range(0, 32767))
                                             : LEVEL_W'((int'(hi) * 4) / 5);
            d = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(0, 65535))
                                            : COUNT_W'($urandom_range(0, 24));
            configure(a, hi, lo, d, CMD_W'($urandom));
            phase_end = sent + $urandom_range(80, 160);
            while (sent < phase_end) begin
                sender_idle   = $urandom_range(0, 3) != 0;
                receiver_idle = $urandom_range(0, 3) != 0;
                kind = $urandom_range(0, 9);
                if (kind < 4) begin
                    // push the average above the arming level
                    n = $urandom_range(1, 6);
                    repeat (n) send_item(OP_SAMPLE, force_with_magnitude(
                        (int'(m_thr_hi) < 32767) ? int'(m_thr_hi) + 1 : 32767, 32767));
                end else if (kind < 7) begin
                    n = $urandom_range(1, ((int'(m_delay) > 30) ? 30 : int'(m_delay)) + 2);
                    repeat (n) send_tick();
                end else if (kind < 9) begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_item(OP_SAMPLE, force_with_magnitude(0, m_thr_lo / 2));
                end else begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_item(1'($urandom_range(0, 1)), SAMPLE_WIDTH'($urandom));
                end
                sent += n;
                if ($urandom_range(0, 15) == 0) drain_results();
            end
        end
        drain_results();
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_SAMPLE;
        in_ch.force_sample <= '0;
        fault_count        = 0;
        cycle_count        = 0;
        sender_idle        = 1'b1;
        receiver_idle      = 1'b1;
        m_alpha            = ALPHA_RESET;
        m_thr_hi           = THRESH_HI_RESET;
        m_thr_lo           = THRESH_LO_RESET;
        m_delay            = DELAY_RESET;
        m_command          = COMMAND_RESET;
        m_level            = '0;
        m_phase            = PHASE_IDLE;
        m_ticks            = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_short_delays();
        test_threshold_extremes();
        test_unused_index();
        test_longest_delay();
        test_random_traffic();

        drain_results();
        if (fault_count == 0 && trigger_outputs.size() == 0) begin
            $display("force_trigger_ema_hysteresis regression: pass");
        end else begin
            $display("force_trigger_ema_hysteresis regression: fail");
        end
        $finish;
    end

endmodule
